/* design/cln_pkg.sv */
// shared types, constants and event tables for the character display nibble sequencer
`default_nettype none
package cln_pkg;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 40;

  localparam logic [2:0] ReqInit  = 3'd0;
  localparam logic [2:0] ReqClear = 3'd1;
  localparam logic [2:0] ReqHome  = 3'd2;
  localparam logic [2:0] ReqGoto  = 3'd3;
  localparam logic [2:0] ReqChar  = 3'd4;

  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdHome     = 8'h02;
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] CmdFuncSet  = 8'h28;
  localparam logic [7:0] CmdDispOn   = 8'h0C;
  localparam logic [7:0] CmdEntry    = 8'h06;
  localparam logic [3:0] NibWake     = 4'h3;
  localparam logic [3:0] NibFour     = 4'h2;

  localparam logic [15:0] PowerUpUs   = 16'd50000;
  localparam logic [12:0] WakeFirstUs = 13'd5000;
  localparam logic [12:0] WakeNextUs  = 13'd100;
  localparam logic [12:0] SettleUs    = 13'd50;
  localparam logic [12:0] LongCmdUs   = 13'd2050;

  localparam logic [3:0] InitLastStep = 4'd13;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic       long_wait;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } event_t;

  function automatic event_t byte_event(input cmd_t cmd, input logic low_half);
    event_t ev;
    ev.rs          = cmd.rs;
    ev.nibble      = low_half ? cmd.data[3:0] : cmd.data[7:4];
    ev.wait_before = '0;
    ev.wait_after  = !low_half ? '0 : (cmd.long_wait ? LongCmdUs : SettleUs);
    ev.last        = low_half;
    return ev;
  endfunction

  function automatic event_t init_event(input logic [3:0] step);
    event_t ev;
    ev.rs          = 1'b0;
    ev.wait_before = '0;
    ev.wait_after  = '0;
    ev.last        = 1'b0;
    ev.nibble      = '0;
    case (step)
      4'd0: begin
        ev.nibble      = NibWake;
        ev.wait_before = PowerUpUs;
        ev.wait_after  = WakeFirstUs;
      end
      4'd1: begin
        ev.nibble     = NibWake;
        ev.wait_after = WakeNextUs;
      end
      4'd2:  ev.nibble = NibWake;
      4'd3:  ev.nibble = NibFour;
      4'd4:  ev.nibble = CmdFuncSet[7:4];
      4'd5: begin
        ev.nibble     = CmdFuncSet[3:0];
        ev.wait_after = SettleUs + SettleUs;
      end
      4'd6:  ev.nibble = CmdFuncSet[7:4];
      4'd7: begin
        ev.nibble     = CmdFuncSet[3:0];
        ev.wait_after = SettleUs;
      end
      4'd8:  ev.nibble = CmdDispOn[7:4];
      4'd9: begin
        ev.nibble     = CmdDispOn[3:0];
        ev.wait_after = SettleUs;
      end
      4'd10: ev.nibble = CmdEntry[7:4];
      4'd11: begin
        ev.nibble     = CmdEntry[3:0];
        ev.wait_after = SettleUs;
      end
      4'd12: ev.nibble = CmdClear[7:4];
      InitLastStep: begin
        ev.nibble     = CmdClear[3:0];
        ev.wait_after = LongCmdUs;
        ev.last       = 1'b1;
      end
      default: ev.nibble = '0;
    endcase
    return ev;
  endfunction

endpackage
`default_nettype wire

/* design/cln_front.sv */
// request decoder: turns an accepted request into a queued command
`default_nettype none
module cln_front
  import cln_pkg::*;
(
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [InDataW-1:0] in_tdata,
  input  wire logic [InUserW-1:0] in_tuser,
  input  wire logic               q_full,
  output logic                    push,
  output cmd_t                    push_cmd
);

  logic known;

  always_comb begin
    known    = 1'b1;
    push_cmd = '0;
    unique case (in_tuser)
      ReqInit: begin
        push_cmd.is_init = 1'b1;
      end
      ReqClear: begin
        push_cmd.data      = CmdClear;
        push_cmd.long_wait = 1'b1;
      end
      ReqHome: begin
        push_cmd.data      = CmdHome;
        push_cmd.long_wait = 1'b1;
      end
      ReqGoto: begin
        // line base 0x40 lands on bit 6, column fills bits 5..0
        push_cmd.data = CmdSetAddr | {1'b0, in_tdata[8], in_tdata[14:9]};
      end
      ReqChar: begin
        push_cmd.rs   = 1'b1;
        push_cmd.data = in_tdata[7:0];
      end
      default: known = 1'b0;
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && known;

endmodule
`default_nettype wire

/* design/cln_queue.sv */
// small command queue between the decoder and the strobe sequencer
`default_nettype none
module cln_queue
  import cln_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

endmodule
`default_nettype wire

/* design/cln_back.sv */
// strobe sequencer: walks the head command and registers one event per cycle while the output is not stalled
`default_nettype none
module cln_back
  import cln_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire cmd_t                head_cmd,
  output logic                     pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  event_t     ev_r;
  event_t     ev_cur;
  logic       load;

  always_comb begin
    ev_cur = head_cmd.is_init ? init_event(step_r) : byte_event(head_cmd, step_r[0]);
    load   = head_valid && (!valid_r || out_tready);
    pop    = load && ev_cur.last;
    step_nxt  = step_r;
    valid_nxt = valid_r && !out_tready;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = ev_cur.last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= ev_cur;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = ev_r.rs;
  assign out_tlast  = ev_r.last;
  assign out_tdata  = {7'd0, ev_r.wait_after, ev_r.wait_before, ev_r.nibble};

endmodule
`default_nettype wire

/* design/char_lcd_nibble_sequencer_unit.sv */
// top level of the character display nibble sequencer
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser request kind, tdata char/row/column
// out_     out  tvalid/tready      tuser register select, tdata nibble/waits, tlast
//
// initialize gives 14 strobe events, clear/home/goto/char give 2, one per cycle while out_ is not stalled
// the back sequencer stepping the head command sets that pace
// a request is taken every cycle while the command queue has room
// rst_n is synchronous; it empties the queue and the output register
// the queue lets requests arrive while the output is stalled
`default_nettype none
module char_lcd_nibble_sequencer_unit
  import cln_pkg::*;
#(
  parameter int unsigned QDEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // char_code[7:0], row[8], column[14:9]
  input  wire logic [InUserW-1:0]  in_tuser,   // req_type[2:0]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,  // nibble[3:0], wait_before_us[19:4], wait_after_us[32:20]
  output logic                     out_tuser,  // reg_select
  output logic                     out_tlast
);

  logic q_full;
  logic push;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  cln_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cln_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cln_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* design/cln_checker.sv */
// port-level checks on the nibble sequencer, bound to the top level
`default_nettype none
module cln_checker
  import cln_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tuser,
  input wire logic                out_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_power_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[19:4] != 16'd0) |->
      (out_tdata[3:0] == NibWake) && !out_tuser && !out_tlast)
    else $error("pre-strobe wait on wrong event");

  a_char_settle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> out_tdata[32:20] == SettleUs)
    else $error("character low nibble settle wrong");

  a_char_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tlast |-> out_tdata[32:4] == 29'd0)
    else $error("character high nibble carries a wait");

endmodule

bind char_lcd_nibble_sequencer_unit cln_checker u_cln_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
